FILE: hdl/vdh_pkg.sv
// Package for the v-disparity histogram block: widths, codes, constants,
// controller state type and the command/status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vdh_pkg;

  localparam int MAX_ROWS_DEF = 1024;
  localparam int NUM_BINS     = 256;

  localparam int ACT_W   = 2;
  localparam int ROW_W   = 10;
  localparam int DISP_W  = 8;
  localparam int COUNT_W = 8;
  localparam int CFG_W   = 10;
  localparam int CFG_IDX_W = 1;

  typedef logic [ACT_W-1:0] action_t;
  localparam action_t ACT_CLEAR = 2'd0;
  localparam action_t ACT_COUNT = 2'd1;
  localparam action_t ACT_READ  = 2'd2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_VROW   = 1'd0;
  localparam cfg_idx_t CFG_THRESH = 1'd1;

  localparam logic [ROW_W-1:0]   VROW_RESET   = 10'd0;
  localparam logic [COUNT_W-1:0] THRESH_RESET = 8'd10;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = 8'd255;
  localparam logic [DISP_W-1:0]  DISP_MIN     = 8'd7;
  localparam logic [DISP_W-1:0]  DISP_MAX     = 8'd252;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic load;     // capture item, issue bin read
    logic exec;     // write back count or emit read result
    logic clr_run;  // clear sweep step
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last; // sweep address is at the last bin
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: hdl/v_disparity_histogram_top.sv
// Top level of the v-disparity histogram block: joins the controller FSM
// and the datapath. Depends on vdh_pkg, vdh_ctrl and vdh_datapath.
`timescale 1ns / 1ps
`default_nettype none

// V-disparity histogram. One 8-bit saturating bin per (row, disparity),
// MAX_ROWS x 256 bins in a single-port-write, registered-read memory.
// A beat is taken at a clock edge with start high and busy low.
// A count or read beat passes the load step, which issues the registered
// bin read, then the execute step, which writes back or registers the
// result; the memory read-modify-write sets this. A read result shows on
// out_valid / out_bin_count for exactly one cycle, after the beat has passed
// the execute state and the result register; the receiver cannot stall it,
// so it must sample that cycle. A new beat may be taken in the same cycle
// a result is shown. A clear beat, and reset as well, runs a clearing pass
// over all MAX_ROWS * 256 bins (262144 at the default), writing one bin per
// cycle, busy high throughout. Action code 3 is taken and dropped. Config
// writes (cfg_we, cfg_index, cfg_data) land at once; issue them only while
// busy is low and no result is pending.

module v_disparity_histogram_top #(
  parameter int MAX_ROWS = vdh_pkg::MAX_ROWS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // command channel
  input  wire                          start,
  output logic                         busy,
  input  wire [vdh_pkg::ACT_W-1:0]     in_action,
  input  wire [vdh_pkg::ROW_W-1:0]     in_row,
  input  wire [vdh_pkg::DISP_W-1:0]    in_disparity,
  // result channel
  output logic                         out_valid,
  output logic [vdh_pkg::COUNT_W-1:0]  out_bin_count,
  // config write port
  input  wire                          cfg_we,
  input  wire [vdh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [vdh_pkg::CFG_W-1:0]     cfg_data
);

  // controller -> datapath commands, datapath -> controller status
  vdh_pkg::ctrl_cmd_t cmd;
  vdh_pkg::dp_sts_t   sts;

  vdh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  vdh_datapath #(
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_row        (in_row),
    .in_disparity  (in_disparity),
    .in_action     (in_action),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_bin_count (out_bin_count)
  );

endmodule

`default_nettype wire

FILE: hdl/vdh_ctrl.sv
// Controller FSM of the v-disparity histogram: sequences item load,
// execute and the bin clear sweep. Depends on vdh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vdh_ctrl (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    start,
  input  wire vdh_pkg::action_t  in_action,
  input  wire vdh_pkg::dp_sts_t  sts,
  output vdh_pkg::ctrl_cmd_t     cmd,
  output logic                   busy
);

  vdh_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vdh_pkg::ST_CLEAR;  // store is swept clear after reset
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    busy        = 1'b1;
    case (state_r)
      vdh_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          case (in_action)
            vdh_pkg::ACT_CLEAR: begin
              state_nxt = vdh_pkg::ST_CLEAR;
            end
            vdh_pkg::ACT_COUNT, vdh_pkg::ACT_READ: begin
              cmd.load  = 1'b1;
              state_nxt = vdh_pkg::ST_EXEC;
            end
            default: begin
              state_nxt = vdh_pkg::ST_IDLE;  // unused code: dropped
            end
          endcase
        end
      end
      vdh_pkg::ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = vdh_pkg::ST_IDLE;
      end
      vdh_pkg::ST_CLEAR: begin
        cmd.clr_run = 1'b1;
        if (sts.clr_last) begin
          state_nxt = vdh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = vdh_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/vdh_datapath.sv
// Datapath of the v-disparity histogram: config registers, bin memory,
// saturating update, thresholded read and clear sweep counter.
// Depends on vdh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vdh_datapath #(
  parameter int MAX_ROWS = vdh_pkg::MAX_ROWS_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire vdh_pkg::ctrl_cmd_t       cmd,
  output vdh_pkg::dp_sts_t              sts,
  input  wire [vdh_pkg::ROW_W-1:0]      in_row,
  input  wire [vdh_pkg::DISP_W-1:0]     in_disparity,
  input  wire vdh_pkg::action_t         in_action,
  input  wire                           cfg_we,
  input  wire vdh_pkg::cfg_idx_t        cfg_index,
  input  wire [vdh_pkg::CFG_W-1:0]      cfg_data,
  output logic                          out_valid,
  output logic [vdh_pkg::COUNT_W-1:0]   out_bin_count
);

  localparam int MROW_W = $clog2(MAX_ROWS);
  localparam int ADDR_W = MROW_W + vdh_pkg::DISP_W;
  localparam int DEPTH  = MAX_ROWS * vdh_pkg::NUM_BINS;

  logic [vdh_pkg::COUNT_W-1:0] mem [DEPTH];

  logic [vdh_pkg::ROW_W-1:0]   vrow_r;
  logic [vdh_pkg::COUNT_W-1:0] thresh_r;

  // captured item
  logic                        is_count_r;
  logic                        row_ok_r;
  logic [vdh_pkg::ROW_W-1:0]   row_r;
  logic [vdh_pkg::DISP_W-1:0]  disp_r;
  logic [ADDR_W-1:0]           addr_r;
  logic [vdh_pkg::COUNT_W-1:0] rd_data_r;

  logic [ADDR_W-1:0]           clr_addr_r, clr_addr_nxt;
  logic [ADDR_W-1:0]           in_addr;
  logic                        in_row_ok;

  logic                        cnt_hit;
  logic [vdh_pkg::COUNT_W-1:0] cnt_val;
  logic [vdh_pkg::COUNT_W-1:0] rd_val;
  logic                        mem_we;
  logic [ADDR_W-1:0]           mem_waddr;
  logic [vdh_pkg::COUNT_W-1:0] mem_wdata;

  logic                        out_valid_r;
  logic [vdh_pkg::COUNT_W-1:0] out_bin_count_r;

  assign in_addr   = {MROW_W'(in_row), in_disparity};
  assign in_row_ok = (32'(in_row) < 32'(MAX_ROWS));

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vrow_r   <= vdh_pkg::VROW_RESET;
      thresh_r <= vdh_pkg::THRESH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        vdh_pkg::CFG_VROW:   vrow_r   <= cfg_data;
        vdh_pkg::CFG_THRESH: thresh_r <= cfg_data[vdh_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_count_r <= (in_action == vdh_pkg::ACT_COUNT);
      row_ok_r   <= in_row_ok;
      row_r      <= in_row;
      disp_r     <= in_disparity;
      addr_r     <= in_addr;
    end
  end

  // clear sweep address
  assign sts.clr_last = (clr_addr_r == ADDR_W'(DEPTH - 1));

  always_comb begin
    clr_addr_nxt = clr_addr_r;
    if (cmd.clr_run) begin
      clr_addr_nxt = sts.clr_last ? '0 : clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else begin
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // saturating update and thresholded read
  always_comb begin
    cnt_hit = is_count_r && row_ok_r && (row_r >= vrow_r) &&
              (disp_r inside {[vdh_pkg::DISP_MIN:vdh_pkg::DISP_MAX]});
    cnt_val = (rd_data_r == vdh_pkg::COUNT_MAX) ? rd_data_r : rd_data_r + 1'b1;
    rd_val  = row_ok_r ? rd_data_r : '0;
    if (rd_val <= thresh_r) begin
      rd_val = '0;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = cnt_val;
    if (cmd.clr_run) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else if (cmd.exec && cnt_hit) begin
      mem_we = 1'b1;
    end
  end

  // bin memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.load) begin
      rd_data_r <= mem[in_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.exec && !is_count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_bin_count_r <= rd_val;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_bin_count = out_bin_count_r;

endmodule

`default_nettype wire

FILE: verif/tb_v_disparity_histogram_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for v_disparity_histogram_top: a queued command driver,
// a result monitor and an in-bench histogram predictor. Depends on vdh_pkg.

module tb_v_disparity_histogram_top;

  // Action code 3 is unused by the block: taken and dropped
  localparam vdh_pkg::action_t ACT_NOP = 2'd3;

  // A clearing pass writes MAX_ROWS*256 bins. The run has two of them: one after reset and
  // one for the clear beat. The limit is several times the slowest run.
  localparam int LIMIT_CYCLES  = 3_000_000;
  // Results are registered after the beat's execute state. Wait past that before config.
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASE_BEATS   = 312;

  // One bin that takes the largest share of counts, so that it reaches saturation mid-run.
  // Row 1023 is never above the vanishing row, whatever the setting.
  localparam logic [vdh_pkg::ROW_W-1:0]  HOT_ROW  = 10'd1023;
  localparam logic [vdh_pkg::DISP_W-1:0] HOT_DISP = 8'd200;

  typedef struct packed {
    vdh_pkg::action_t            act;
    logic [vdh_pkg::ROW_W-1:0]   row;
    logic [vdh_pkg::DISP_W-1:0]  disp;
  } vdh_cmd_t;

  typedef struct packed {
    logic [vdh_pkg::ROW_W-1:0]   row;
    logic [vdh_pkg::DISP_W-1:0]  disp;
    logic [vdh_pkg::COUNT_W-1:0] count;
  } bin_read_t;

  logic                          clk           = 1'b0;
  logic                          rst_n         = 1'b0;
  logic                          start         = 1'b0;
  logic                          busy;
  logic [vdh_pkg::ACT_W-1:0]     in_action     = vdh_pkg::ACT_CLEAR;
  logic [vdh_pkg::ROW_W-1:0]     in_row        = '0;
  logic [vdh_pkg::DISP_W-1:0]    in_disparity  = '0;
  logic                          out_valid;
  logic [vdh_pkg::COUNT_W-1:0]   out_bin_count;
  logic                          cfg_we        = 1'b0;
  logic [vdh_pkg::CFG_IDX_W-1:0] cfg_index     = vdh_pkg::CFG_VROW;
  logic [vdh_pkg::CFG_W-1:0]     cfg_data      = '0;

  // Predictor state: only bins that were ever counted are stored. A missing key reads as 0.
  logic [vdh_pkg::COUNT_W-1:0] bin_tally [int];
  logic [vdh_pkg::ROW_W-1:0]   vrow_cfg   = vdh_pkg::VROW_RESET;
  logic [vdh_pkg::COUNT_W-1:0] thresh_cfg = vdh_pkg::THRESH_RESET;

  vdh_cmd_t  cmd_backlog [$];   // commands waiting for the driver
  bin_read_t pending_reads [$]; // predicted read results, oldest first
  vdh_cmd_t  drv_cmd;           // command on the in_ ports right now

  int idle_pct      = 0;
  int fail_cnt      = 0;
  int beats_taken   = 0;
  int reads_checked = 0;
  int sat_hits      = 0;
  int clears_seen   = 0;
  int cycle_cnt     = 0;

  v_disparity_histogram_top i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_action     (in_action),
    .in_row        (in_row),
    .in_disparity  (in_disparity),
    .out_valid     (out_valid),
    .out_bin_count (out_bin_count),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Histogram predictor: applies one taken beat to the bins. A read beat queues
  // the expected bin_count.
  function automatic void histogram_apply(vdh_cmd_t c);
    int                          key;
    logic [vdh_pkg::COUNT_W-1:0] v;
    bin_read_t                   r;
    key = int'({c.row, c.disp});
    case (c.act)
      vdh_pkg::ACT_CLEAR: begin
        bin_tally.delete();
        clears_seen++;
      end
      vdh_pkg::ACT_COUNT: begin
        // Count only rows at or below the horizon, and only disparities in 7..252
        if (c.row >= vrow_cfg && c.disp >= vdh_pkg::DISP_MIN &&
            c.disp <= vdh_pkg::DISP_MAX) begin
          v = bin_tally.exists(key) ? bin_tally[key] : '0;
          if (v == vdh_pkg::COUNT_MAX)
            sat_hits++;
          else
            bin_tally[key] = v + 1'b1;
        end
      end
      vdh_pkg::ACT_READ: begin
        v = bin_tally.exists(key) ? bin_tally[key] : '0;
        // Noise suppression: counts not above the threshold read as zero
        if (v <= thresh_cfg)
          v = '0;
        r.row   = c.row;
        r.disp  = c.disp;
        r.count = v;
        pending_reads.insert(pending_reads.size(), r);
      end
      default: ; // unused code, no effect
    endcase
  endfunction

  // Random command. Most counts and reads go to the hot bin and a few warm bins near
  // the disparity limits. The rest are spread over the whole field range.
  function automatic vdh_cmd_t rand_cmd();
    vdh_cmd_t c;
    int       a;
    int       s;
    a = $urandom_range(99);
    c.act = (a < 62) ? vdh_pkg::ACT_COUNT : (a < 90) ? vdh_pkg::ACT_READ : ACT_NOP;
    s = $urandom_range(99);
    if (s < 40) begin
      c.row  = HOT_ROW;
      c.disp = HOT_DISP;
    end else if (s < 70) begin
      c.row  = 10'd1020 + 10'($urandom_range(3));
      c.disp = $urandom_range(1) ? 8'(6 + $urandom_range(3)) : 8'(250 + $urandom_range(3));
    end else begin
      c.row  = 10'($urandom_range(1023));
      c.disp = 8'($urandom_range(255));
    end
    return c;
  endfunction

  task automatic queue_cmd(input vdh_pkg::action_t act, input int row, input int disp);
    vdh_cmd_t c;
    c.act  = act;
    c.row  = 10'(row);
    c.disp = 8'(disp);
    cmd_backlog.insert(cmd_backlog.size(), c);
  endtask

  // Config write at a clock edge. Call only while the block is idle.
  task automatic write_reg(input vdh_pkg::cfg_idx_t idx,
                           input logic [vdh_pkg::CFG_W-1:0] d);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == vdh_pkg::CFG_VROW)
      vrow_cfg = d[vdh_pkg::ROW_W-1:0];
    else
      thresh_cfg = d[vdh_pkg::COUNT_W-1:0];
  endtask

  // Wait until all beats are taken, the block is idle and every read has returned
  task automatic drain();
    while (cmd_backlog.size() != 0 || start) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_reads.size() != 0) begin
      $display("%0t ns: %0d predicted bin reads never returned", $time, pending_reads.size());
      fail_cnt += pending_reads.size();
      pending_reads.delete();
    end
  endtask

  task automatic run_phase(input logic [vdh_pkg::ROW_W-1:0] vrow,
                           input logic [vdh_pkg::COUNT_W-1:0] thr,
                           input int idle, input int n);
    logic [vdh_pkg::CFG_W-vdh_pkg::COUNT_W-1:0] pad;
    vdh_cmd_t                                   c;
    int                                         made;
    // The upper bits of the threshold write are don't-care. Drive them at random.
    pad = (vdh_pkg::CFG_W-vdh_pkg::COUNT_W)'($urandom_range(3));
    write_reg(vdh_pkg::CFG_VROW, vrow);
    write_reg(vdh_pkg::CFG_THRESH, {pad, thr});
    idle_pct = idle;
    made = 0;
    while (made < n) begin
      c = rand_cmd();
      cmd_backlog.insert(cmd_backlog.size(), c);
      made++;
    end
    drain();
  endtask

  // Driver. It holds the beat while busy. When a beat is taken, it predicts the beat
  // and then loads the next one or idles.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        histogram_apply(drv_cmd);
        beats_taken++;
      end
      if (cmd_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
        drv_cmd = cmd_backlog.pop_front();
        start        <= 1'b1;
        in_action    <= drv_cmd.act;
        in_row       <= drv_cmd.row;
        in_disparity <= drv_cmd.disp;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor. A result is valid for one cycle only. Check it against the oldest prediction.
  always @(posedge clk) begin
    bin_read_t e;
    if (rst_n && out_valid) begin
      if (pending_reads.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual bin_count %0d",
                 $time, out_bin_count);
        fail_cnt++;
      end else begin
        e = pending_reads.pop_front();
        reads_checked++;
        if (out_bin_count !== e.count) begin
          $display("%0t ns: bin_count mismatch at row %0d disp %0d, expected %0d actual %0d",
                   $time, e.row, e.disp, e.count, out_bin_count);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("%0t ns: timeout after %0d cycles", $time, cycle_cnt);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // Reset starts a clearing pass. Config writes wait until it is over.
    repeat (2) @(posedge clk);
    while (busy) @(posedge clk);

    // Directed part. The horizon is at row 5. Threshold 0 makes single counts visible.
    write_reg(vdh_pkg::CFG_VROW, 10'd5);
    write_reg(vdh_pkg::CFG_THRESH, 10'd0);
    idle_pct = 11;
    queue_cmd(vdh_pkg::ACT_COUNT, 5, 7);       // first counted row, lowest valid disparity
    queue_cmd(vdh_pkg::ACT_COUNT, 4, 7);       // above horizon: dropped
    queue_cmd(vdh_pkg::ACT_COUNT, 1023, 252);  // last row, highest valid disparity
    queue_cmd(vdh_pkg::ACT_COUNT, 1023, 252);
    queue_cmd(vdh_pkg::ACT_COUNT, 5, 6);       // disparity just below the range
    queue_cmd(vdh_pkg::ACT_COUNT, 5, 253);     // disparity just above the range
    queue_cmd(vdh_pkg::ACT_COUNT, 0, 0);
    queue_cmd(vdh_pkg::ACT_COUNT, 1023, 255);
    queue_cmd(vdh_pkg::ACT_COUNT, 682, 170);   // alternating bit patterns
    queue_cmd(ACT_NOP, 1023, 255);             // unused code: no result, no effect
    queue_cmd(vdh_pkg::ACT_READ, 5, 7);
    queue_cmd(vdh_pkg::ACT_READ, 4, 7);
    queue_cmd(vdh_pkg::ACT_READ, 1023, 252);
    queue_cmd(vdh_pkg::ACT_READ, 5, 6);
    queue_cmd(vdh_pkg::ACT_READ, 5, 253);
    queue_cmd(vdh_pkg::ACT_READ, 0, 0);
    queue_cmd(vdh_pkg::ACT_READ, 1023, 255);
    queue_cmd(vdh_pkg::ACT_READ, 682, 170);
    queue_cmd(vdh_pkg::ACT_CLEAR, 0, 0);       // full clearing pass
    queue_cmd(vdh_pkg::ACT_READ, 5, 7);
    queue_cmd(vdh_pkg::ACT_READ, 1023, 252);
    drain();

    // Random phases. Each step moves the horizon; all but the first move the threshold.
    // Extremes included. The sender idles at 11%, then at 84%, then never.
    run_phase(10'd0,    8'd0,   11, PHASE_BEATS);
    run_phase(10'd1023, 8'd255, 84, PHASE_BEATS);
    run_phase(10'd512,  8'd100, 0,  PHASE_BEATS);
    run_phase(10'd300,  8'd10,  0,  PHASE_BEATS);

    $display("Run covered %0d beats taken, %0d reads checked, %0d clear beats,",
             beats_taken, reads_checked, clears_seen);
    $display("and %0d counts into a bin that was already full, over five config settings.",
             sat_hits);
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
